### design/double_clap_detector_defines.svh
// assertion macros shared by the double clap detector rtl
`ifndef DOUBLE_CLAP_DETECTOR_DEFINES_SVH
`define DOUBLE_CLAP_DETECTOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define DCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### design/dcd_pkg.sv
// shared types and constants of the double clap detector
package dcd_pkg;

   localparam int ACC_BITS_DEFAULT = 32;

   localparam int SAMPLE_W = 10;
   localparam int TIME_W   = 32;
   localparam int WAIT_W   = 16;
   localparam int PCT_W    = 7;
   localparam int SLOPE_W  = SAMPLE_W + 1;
   localparam int PROD_W   = SAMPLE_W + PCT_W;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WAIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_PCT = 2'd2;

   localparam logic [WAIT_W-1:0] MAX_WAIT_RESET  = 16'd1000;
   localparam logic [WAIT_W-1:0] DEAD_ZONE_RESET = 16'd100;
   localparam logic [PCT_W-1:0]  LIMIT_PCT_RESET = 7'd3;

   localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_EVAL
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### design/dcd_div.sv
// bit-serial restoring divider for the running mean
`include "double_clap_detector_defines.svh"

module dcd_div
   import dcd_pkg::*;
#(
   parameter int ACC_BITS = ACC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ACC_BITS-1:0] dividend,
   input  logic [ACC_BITS-1:0] divisor,
   output div_status_type      status,
   output logic [SAMPLE_W-1:0] quotient
);

   localparam int CNT_W = $clog2(ACC_BITS + 1);

   logic [ACC_BITS-1:0] rem_ff, rem_in;
   logic [ACC_BITS-1:0] dvd_ff, dvd_in;
   logic [ACC_BITS-1:0] dsr_ff, dsr_in;
   logic [SAMPLE_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [ACC_BITS-1:0] trial;
   logic [ACC_BITS-1:0] diff;
   logic                fits;

   assign trial = {rem_ff[ACC_BITS-2:0], dvd_ff[ACC_BITS-1]};
   assign fits  = trial >= dsr_ff;
   assign diff  = trial - dsr_ff;

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         quot_in = '0;
         cnt_in  = CNT_W'(ACC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff : trial;
         dvd_in  = {dvd_ff[ACC_BITS-2:0], 1'b0};
         quot_in = {quot_ff[SAMPLE_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

   `DCD_ASSERT_NOW(a_rem_below_half, clock, reset, busy_ff, !rem_ff[ACC_BITS-1])
   `DCD_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff)
   `DCD_ASSERT_NOW(a_done_idle, clock, reset, done_ff, !busy_ff)

endmodule

### design/double_clap_detector.sv
// top level of the double clap detector
`include "double_clap_detector_defines.svh"

// Double clap detector. Each req transaction carries one sound sample with its
// millisecond time stamp and gives exactly one rsp transaction. The running
// mean is found by a bit-serial divider that retires one quotient bit per
// cycle. A transaction that uses its sample passes through a capture step,
// the window and dead zone compares, the divider and an evaluate step. A
// sample that arrives after the window of a pending peak has run out skips
// the divider and gets an all-zero rsp. A result waiting in the rsp register
// does not block acceptance of the next req transaction, but that one stalls
// before its own rsp until the register is free. Write the registers through
// the csr port only while the block is idle; the block does not enforce this.
module double_clap_detector
   import dcd_pkg::*;
#(
   parameter int ACC_BITS = ACC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // sample[9:0], time_ms[41:10], stats_only[42], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // triggered[0], sample_taken[1], reported_sample[11:2], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   state_type               state_ff, state_in;
   logic [SAMPLE_W-1:0]     sample_ff, sample_in;
   logic [TIME_W-1:0]       time_ff, time_in;
   logic                    tweak_ff, tweak_in;
   logic [ACC_BITS-2:0]     sum_ff, sum_in;
   logic [ACC_BITS-2:0]     cnt_ff, cnt_in;
   logic [ACC_BITS-2:0]     dev_sum_ff, dev_sum_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [TIME_W-1:0]       pend_time_ff, pend_time_in;
   logic                    ign_valid_ff, ign_valid_in;
   logic [TIME_W-1:0]       ign_time_ff, ign_time_in;
   logic [SAMPLE_W-1:0]     last_wave_ff, last_wave_in;
   logic [SLOPE_W-1:0]      slope_ff, slope_in;
   logic                    in_window_ff, in_window_in;
   logic                    dz_over_ff, dz_over_in;
   logic [WAIT_W-1:0]       max_wait_ff, max_wait_in;
   logic [WAIT_W-1:0]       dead_zone_ff, dead_zone_in;
   logic [PCT_W-1:0]        limit_ff, limit_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;

   logic [TIME_W-1:0]       pend_elapsed;
   logic [TIME_W-1:0]       ign_elapsed;
   logic                    timeout;
   logic                    out_free;
   logic [ACC_BITS-1:0]     nsum;
   logic [ACC_BITS-1:0]     ncnt;
   logic [ACC_BITS-1:0]     ndev;
   logic [SAMPLE_W-1:0]     mean;
   logic [SAMPLE_W-1:0]     dev;
   logic                    overflow;
   logic [PROD_W-1:0]       dev_scaled;
   logic [PROD_W-1:0]       threshold;
   logic [SLOPE_W-1:0]      slope_work;
   logic                    peak;
   logic                    trig;
   logic                    div_start;
   div_status_type          div_status;

   assign pend_elapsed = time_ff - pend_time_ff;
   assign ign_elapsed  = time_ff - ign_time_ff;
   assign timeout      = pend_valid_ff &&
                         (pend_elapsed > TIME_W'(max_wait_ff));
   assign out_free     = !rsp_tvalid_ff || rsp_tready;

   assign nsum = {1'b0, sum_ff} + ACC_BITS'(sample_ff);
   assign ncnt = {1'b0, cnt_ff} + ACC_BITS'(1);

   dcd_div #(
      .ACC_BITS (ACC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (nsum),
      .divisor  (ncnt),
      .status   (div_status),
      .quotient (mean)
   );

   assign dev        = (sample_ff >= mean) ? (sample_ff - mean) : (mean - sample_ff);
   assign ndev       = {1'b0, dev_sum_ff} + ACC_BITS'(dev);
   assign overflow   = nsum[ACC_BITS-1] || ndev[ACC_BITS-1] || ncnt[ACC_BITS-1];
   assign dev_scaled = PROD_W'(dev) * PROD_W'(PCT_SCALE);
   assign threshold  = PROD_W'(mean) * PROD_W'(limit_ff);

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      sample_in     = sample_ff;
      time_in       = time_ff;
      tweak_in      = tweak_ff;
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      dev_sum_in    = dev_sum_ff;
      pend_valid_in = pend_valid_ff;
      pend_time_in  = pend_time_ff;
      ign_valid_in  = ign_valid_ff;
      ign_time_in   = ign_time_ff;
      last_wave_in  = last_wave_ff;
      slope_in      = slope_ff;
      in_window_in  = in_window_ff;
      dz_over_in    = dz_over_ff;
      max_wait_in   = max_wait_ff;
      dead_zone_in  = dead_zone_ff;
      limit_in      = limit_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      div_start     = 1'b0;
      slope_work    = slope_ff;
      peak          = 1'b0;
      trig          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sample_in = req_tdata[SAMPLE_W-1:0];
               time_in   = req_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
               tweak_in  = req_tdata[SAMPLE_W+TIME_W];
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (timeout) begin
               if (out_free) begin
                  pend_valid_in = 1'b0;
                  pend_time_in  = '0;
                  last_wave_in  = '0;
                  ign_valid_in  = 1'b0;
                  ign_time_in   = '0;
                  rsp_tvalid_in = 1'b1;
                  rsp_tdata_in  = '0;
                  state_in      = ST_IDLE;
               end
            end else begin
               div_start    = 1'b1;
               in_window_in = pend_elapsed < TIME_W'(max_wait_ff);
               dz_over_in   = ign_elapsed > TIME_W'(dead_zone_ff);
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               if (overflow) begin
                  cnt_in     = (ACC_BITS-1)'(1);
                  sum_in     = (ACC_BITS-1)'(sample_ff);
                  dev_sum_in = '0;
                  slope_in   = '0;
               end else begin
                  sum_in     = nsum[ACC_BITS-2:0];
                  cnt_in     = ncnt[ACC_BITS-2:0];
                  dev_sum_in = ndev[ACC_BITS-2:0];
                  if (!tweak_ff && (!ign_valid_ff || dz_over_ff)) begin
                     ign_valid_in = 1'b0;
                     ign_time_in  = '0;
                     if (last_wave_ff != '0) begin
                        slope_work   = {1'b0, last_wave_ff} - {1'b0, dev};
                        last_wave_in = dev;
                     end
                     slope_in = slope_work;
                     peak = (dev_scaled >= threshold) &&
                            (slope_work[SLOPE_W-1] || (slope_work == '0));
                     if (peak) begin
                        if (pend_valid_ff) begin
                           trig          = in_window_ff;
                           pend_valid_in = 1'b0;
                           pend_time_in  = '0;
                           last_wave_in  = '0;
                        end else begin
                           pend_valid_in = 1'b1;
                           pend_time_in  = time_ff;
                           last_wave_in  = dev;
                        end
                        ign_valid_in = 1'b1;
                        ign_time_in  = time_ff;
                     end
                  end
               end
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_TDATA_W'({sample_ff, 1'b1, trig});
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_WAIT:  max_wait_in  = csr_wdata[WAIT_W-1:0];
            CSR_DEAD_ZONE: dead_zone_in = csr_wdata[WAIT_W-1:0];
            CSR_LIMIT_PCT: limit_in     = csr_wdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         dev_sum_ff    <= '0;
         pend_valid_ff <= 1'b0;
         pend_time_ff  <= '0;
         ign_valid_ff  <= 1'b0;
         ign_time_ff   <= '0;
         last_wave_ff  <= '0;
         slope_ff      <= '0;
         max_wait_ff   <= MAX_WAIT_RESET;
         dead_zone_ff  <= DEAD_ZONE_RESET;
         limit_ff      <= LIMIT_PCT_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
         dev_sum_ff    <= dev_sum_in;
         pend_valid_ff <= pend_valid_in;
         pend_time_ff  <= pend_time_in;
         ign_valid_ff  <= ign_valid_in;
         ign_time_ff   <= ign_time_in;
         last_wave_ff  <= last_wave_in;
         slope_ff      <= slope_in;
         max_wait_ff   <= max_wait_in;
         dead_zone_ff  <= dead_zone_in;
         limit_ff      <= limit_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      time_ff      <= time_in;
      tweak_ff     <= tweak_in;
      in_window_ff <= in_window_in;
      dz_over_ff   <= dz_over_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `DCD_ASSERT_NEXT(a_accept_check, clock, reset, req_tvalid && req_tready, state_ff == ST_CHECK)
   `DCD_ASSERT_NOW(a_done_in_div, clock, reset, div_status.done, state_ff == ST_DIV)
   `DCD_ASSERT_NOW(a_timeout_empty, clock, reset, rsp_tvalid_ff && !rsp_tdata_ff[1], rsp_tdata_ff == '0)

endmodule

### sim/double_clap_detector_tb.sv
// self-checking testbench of the double clap detector with its own prediction of every result
module double_clap_detector_tb;
   import dcd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              stats_only;
      logic [TIME_W-1:0] time_ms;
      logic [SAMPLE_W-1:0] sample;
   } sound_item_type;

   typedef struct packed {
      logic                triggered;
      logic                sample_taken;
      logic [SAMPLE_W-1:0] reported_sample;
   } clap_result_type;

   localparam logic [63:0] ACC_LIMIT = (64'd1 << (ACC_BITS_DEFAULT - 1)) - 64'd1;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // predicted block state and settings
   logic [63:0]         sample_sum;
   logic [63:0]         sample_count;
   logic [63:0]         dev_sum;
   logic                peak_pending;
   logic [TIME_W-1:0]   peak_time;
   logic                quiet_active;
   logic [TIME_W-1:0]   quiet_since;
   logic [SAMPLE_W-1:0] last_wave;
   logic signed [SLOPE_W-1:0] slope;
   logic [WAIT_W-1:0]   cfg_max_wait;
   logic [WAIT_W-1:0]   cfg_dead_zone;
   logic [PCT_W-1:0]    cfg_limit;

   sound_item_type  sound_queue[$];
   clap_result_type clap_expectations[$];
   sound_item_type  req_item;
   int           req_gap = 0;
   int           rsp_gap = 0;
   logic         bursty = 1'b1;
   int           error_count = 0;
   logic [TIME_W-1:0] clock_ms;
   int           phase_items;

   int unsigned phase_win[8]  = '{500, 0, 65535, 2000, 300, 65535, 1500, 1000};
   int unsigned phase_dead[8] = '{50, 0, 65535, 0, 200, 20, 250, 100};
   int unsigned phase_pct[8]  = '{10, 0, 100, 127, 1, 50, 5, 3};

   double_clap_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic clap_result_type predict_clap(sound_item_type it);
      logic [63:0] new_sum;
      logic [63:0] new_cnt;
      logic [63:0] new_dev;
      logic [63:0] mean;
      logic [63:0] dev;
      logic [TIME_W-1:0] since_peak;
      logic [TIME_W-1:0] since_quiet;
      clap_result_type res;
      res = '0;
      since_peak = it.time_ms - peak_time;
      since_quiet = it.time_ms - quiet_since;
      // window of a pending peak ran out: drop it and skip the sample
      if (peak_pending && since_peak > {16'b0, cfg_max_wait}) begin
         peak_pending = 1'b0;
         peak_time = '0;
         last_wave = '0;
         quiet_active = 1'b0;
         quiet_since = '0;
         return res;
      end
      new_sum = sample_sum + it.sample;
      new_cnt = sample_count + 64'd1;
      mean = new_sum / new_cnt;
      dev = (it.sample >= mean) ? it.sample - mean : mean - it.sample;
      new_dev = dev_sum + dev;
      res.sample_taken = 1'b1;
      res.reported_sample = it.sample;
      if (new_sum > ACC_LIMIT || new_dev > ACC_LIMIT || new_cnt > ACC_LIMIT) begin
         sample_count = 64'd1;
         sample_sum = {54'b0, it.sample};
         dev_sum = '0;
         slope = '0;
      end else begin
         sample_sum = new_sum;
         sample_count = new_cnt;
         dev_sum = new_dev;
         if (!it.stats_only && (!quiet_active || since_quiet > {16'b0, cfg_dead_zone})) begin
            quiet_active = 1'b0;
            quiet_since = '0;
            if (last_wave != 0) begin
               slope = $signed({1'b0, last_wave}) - $signed({1'b0, dev[SAMPLE_W-1:0]});
               last_wave = dev[SAMPLE_W-1:0];
            end
            if (dev * 64'd100 >= mean * cfg_limit && slope <= 0) begin
               if (peak_pending) begin
                  if (since_peak < {16'b0, cfg_max_wait}) begin
                     res.triggered = 1'b1;
                  end
                  peak_pending = 1'b0;
                  peak_time = '0;
                  last_wave = '0;
               end else begin
                  peak_pending = 1'b1;
                  peak_time = it.time_ms;
                  last_wave = dev[SAMPLE_W-1:0];
               end
               quiet_active = 1'b1;
               quiet_since = it.time_ms;
            end
         end
      end
      return res;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic add_sound(logic [SAMPLE_W-1:0] sample, logic [TIME_W-1:0] dt, logic tweak);
      sound_item_type it;
      clock_ms += dt;
      it.sample = sample;
      it.time_ms = clock_ms;
      it.stats_only = tweak;
      sound_queue.push_back(it);
      phase_items++;
   endtask

   function automatic logic [SAMPLE_W-1:0] loud_sample();
      return SAMPLE_W'(($urandom_range(0, 1) == 1) ? $urandom_range(950, 1023) :
                                                     $urandom_range(0, 60));
   endfunction

   // baseline, first clap, quiet stretch, second clap placed around the window, trailing baseline
   task automatic add_double_clap();
      int unsigned level;
      int unsigned n;
      int unsigned i;
      int unsigned step;
      int unsigned since_clap;
      int unsigned target;
      int unsigned pick;
      level = $urandom_range(100, 900);
      n = $urandom_range(2, 12);
      for (i = 0; i < n; i++) begin
         add_sound(SAMPLE_W'(level + $urandom_range(0, 8) - 4), $urandom_range(1, 30),
                   $urandom_range(0, 9) == 0);
      end
      add_sound(loud_sample(), $urandom_range(1, 30), 1'b0);
      if ($urandom_range(0, 3) == 0) begin
         since_clap = $urandom_range(0, cfg_dead_zone);
      end else begin
         since_clap = cfg_dead_zone + $urandom_range(1, 30);
      end
      add_sound(SAMPLE_W'(level), since_clap, 1'b0);
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) begin
         step = $urandom_range(1, 5);
         since_clap += step;
         add_sound(SAMPLE_W'(level + $urandom_range(0, 8) - 4), step, 1'b0);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         target = since_clap + $urandom_range(1, (cfg_max_wait > since_clap) ?
                                                 cfg_max_wait - since_clap : 1);
      end else if (pick == 6) begin
         target = cfg_max_wait;
      end else if (pick == 7) begin
         target = cfg_max_wait + 1;
      end else begin
         target = cfg_max_wait + $urandom_range(2, 3000);
      end
      if (target <= since_clap) begin
         target = since_clap + 1;
      end
      add_sound(loud_sample(), target - since_clap, 1'b0);
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
         add_sound(SAMPLE_W'(level + $urandom_range(0, 8) - 4), $urandom_range(1, 30), 1'b0);
      end
   endtask

   task automatic add_noise();
      if ($urandom_range(0, 9) == 0) begin
         clock_ms = $urandom();
      end
      add_sound(SAMPLE_W'($urandom_range(0, 1023)), $urandom_range(0, 200),
                $urandom_range(0, 3) == 0);
   endtask

   task automatic write_settings(logic [WAIT_W-1:0] win_ms, logic [WAIT_W-1:0] dead_ms,
                                 logic [PCT_W-1:0] pct);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_MAX_WAIT;
      csr_wdata <= win_ms;
      @(posedge clock);
      csr_index <= CSR_DEAD_ZONE;
      csr_wdata <= dead_ms;
      @(posedge clock);
      csr_index <= CSR_LIMIT_PCT;
      csr_wdata <= {{(CSR_DATA_W - PCT_W){1'b0}}, pct};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_max_wait = win_ms;
      cfg_dead_zone = dead_ms;
      cfg_limit = pct;
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (sound_queue.size() != 0 || req_tvalid || clap_expectations.size() != 0);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            clap_expectations.push_back(predict_clap(req_item));
         end
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (bursty && $urandom_range(0, 7) == 0) begin
            req_gap = $urandom_range(0, 12);
            req_tvalid <= 1'b0;
         end else if (sound_queue.size() != 0) begin
            req_item = sound_queue.pop_front();
            req_tdata <= {{(REQ_TDATA_W - $bits(sound_item_type)){1'b0}}, req_item};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      clap_result_type want;
      logic ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (clap_expectations.size() == 0) begin
               $error("rsp transaction with nothing outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               want = clap_expectations.pop_front();
               check_field("triggered", 32'(want.triggered), 32'(rsp_tdata[0]));
               check_field("sample_taken", 32'(want.sample_taken), 32'(rsp_tdata[1]));
               check_field("reported_sample", 32'(want.reported_sample),
                           32'(rsp_tdata[11:2]));
            end
         end
         ready_next = 1'b1;
         if (rsp_gap > 0) begin
            rsp_gap--;
            ready_next = 1'b0;
         end else if (bursty && $urandom_range(0, 7) == 0) begin
            rsp_gap = $urandom_range(0, 12);
            ready_next = 1'b0;
         end
         rsp_tready <= ready_next;
      end
   end

   initial begin
      #12_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int p;
      sample_sum = '0;
      sample_count = '0;
      dev_sum = '0;
      peak_pending = 1'b0;
      peak_time = '0;
      quiet_active = 1'b0;
      quiet_since = '0;
      last_wave = '0;
      slope = '0;
      cfg_max_wait = MAX_WAIT_RESET;
      cfg_dead_zone = DEAD_ZONE_RESET;
      cfg_limit = LIMIT_PCT_RESET;
      clock_ms = 32'hFFFF_FC00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, clap pair, timeout, dead zone and window edges, time wrap
      add_sound(10'd0, 0, 1'b1);
      add_sound(10'd1023, 5, 1'b1);
      add_sound(10'd512, 10, 1'b0);
      add_sound(10'd512, 10, 1'b0);
      add_sound(10'd512, 10, 1'b0);
      add_sound(10'd512, 10, 1'b0);
      add_sound(10'd1023, 10, 1'b0);
      add_sound(10'd512, 50, 1'b0);
      add_sound(10'd512, 60, 1'b0);
      add_sound(10'd0, 100, 1'b0);
      add_sound(10'd512, 20, 1'b0);
      add_sound(10'd1023, 200, 1'b0);
      add_sound(10'd512, 1001, 1'b0);
      add_sound(10'd512, 10, 1'b0);
      add_sound(10'd1023, 300, 1'b0);
      add_sound(10'd500, 100, 1'b0);
      add_sound(10'd500, 1, 1'b0);
      add_sound(10'd0, 899, 1'b0);
      add_sound(10'd1023, 5, 1'b1);
      add_sound(10'd1023, 5000, 1'b0);
      wait_idle();

      for (p = 0; p < 8; p++) begin
         repeat (4) @(negedge clock);
         if (p == 7) begin
            bursty = 1'b0;
         end
         write_settings(WAIT_W'(phase_win[p]), WAIT_W'(phase_dead[p]), PCT_W'(phase_pct[p]));
         @(negedge clock);
         phase_items = 0;
         while (phase_items < 125) begin
            if ($urandom_range(0, 9) < 7) begin
               add_double_clap();
            end else begin
               add_noise();
            end
         end
         wait_idle();
      end

      repeat (ACC_BITS_DEFAULT + 8) @(negedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/dcd_pkg.sv
design/dcd_div.sv
design/double_clap_detector.sv
sim/double_clap_detector_tb.sv
